[design/qnr_pkg.sv]
//------------------------------------------------------------------------------
// qnr_pkg
// Shared types and constants of the quartic Newton root refiner.
//------------------------------------------------------------------------------
`default_nettype none

package qnr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int LIMIT_W   = 4;
  localparam int CNT_W     = 5;
  localparam int STAT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_FOUR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_THREE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ZERO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd6;

  localparam logic [STAT_W-1:0] STAT_CONVERGED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LIMIT     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FAULT     = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ISSUE,
    ST_MUL_WAIT,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    STEP_X2,
    STEP_X3,
    STEP_X4,
    STEP_C4X4,
    STEP_C3X3,
    STEP_C2X2,
    STEP_C1X,
    STEP_K4X3,
    STEP_K3X2,
    STEP_K2X
  } step_t;

  typedef struct packed {
    logic done;
    logic ov;
  } unit_stat_t;

endpackage

`default_nettype wire

[design/qnr_if.sv]
//------------------------------------------------------------------------------
// qnr_if
// Valid/ready channels for guess words and result words.
//------------------------------------------------------------------------------
`default_nettype none

interface qnr_in_if
  import qnr_pkg::*;
#(
  parameter int WORD_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] initial_guess;

  modport source (output valid, output initial_guess, input ready);
  modport sink (input valid, input initial_guess, output ready);
endinterface

interface qnr_out_if
  import qnr_pkg::*;
#(
  parameter int WORD_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] root;
  logic        [STAT_W-1:0]     status;
  logic        [CNT_W-1:0]      updates_done;

  modport source (output valid, output root, output status, output updates_done, input ready);
  modport sink (input valid, input root, input status, input updates_done, output ready);
endinterface

`default_nettype wire

[design/qnr_mul.sv]
//------------------------------------------------------------------------------
// qnr_mul
// Digit-serial fixed-point multiplier with truncation and saturation.
//------------------------------------------------------------------------------
`default_nettype none

module qnr_mul
  import qnr_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [WORD_WIDTH-1:0] a,
  input  wire logic signed [WORD_WIDTH-1:0] b,
  output logic signed [WORD_WIDTH-1:0]      res,
  output unit_stat_t                        stat
);

  localparam int W    = WORD_WIDTH;
  localparam int DIG  = 16;
  localparam int NDIG = (W + DIG - 1) / DIG;
  localparam int BW   = NDIG * DIG;
  localparam int PW   = W + BW;
  localparam int CW   = $clog2(NDIG + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  am_r;
  logic [BW-1:0] bm_r;
  logic [PW-1:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          neg_r;
  logic          done_r;
  logic          ov_r;
  logic [W-1:0]  res_r;

  logic [W-1:0]  am_in;
  logic [W-1:0]  bm_in;
  logic [PW-1:0] part;
  logic [PW-1:0] sh;
  logic [PW-1:0] lim;
  logic          ovf;

  assign am_in = a[W-1] ? W'(-a) : W'(a);
  assign bm_in = b[W-1] ? W'(-b) : W'(b);
  assign part  = PW'(am_r * bm_r[BW-1 -: DIG]);
  assign sh    = acc_r >> FRAC_BITS;
  assign lim   = neg_r ? PW'(WMIN) : PW'(WMAX);
  assign ovf   = sh > lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NDIG);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= am_in;
      bm_r  <= BW'(bm_in);
      acc_r <= '0;
      neg_r <= a[W-1] ^ b[W-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        acc_r <= (acc_r << DIG) + part;
        bm_r  <= bm_r << DIG;
      end else begin
        ov_r <= ovf;
        if (ovf) begin
          res_r <= neg_r ? WMIN : WMAX;
        end else begin
          res_r <= neg_r ? W'(-sh[W-1:0]) : sh[W-1:0];
        end
      end
    end
  end

  assign res       = res_r;
  assign stat.done = done_r;
  assign stat.ov   = ov_r;

endmodule

`default_nettype wire

[design/qnr_div.sv]
//------------------------------------------------------------------------------
// qnr_div
// Radix-2 restoring fixed-point divider with truncation and saturation.
//------------------------------------------------------------------------------
`default_nettype none

module qnr_div
  import qnr_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [WORD_WIDTH-1:0] num,
  input  wire logic signed [WORD_WIDTH-1:0] den,
  output logic signed [WORD_WIDTH-1:0]      res,
  output unit_stat_t                        stat
);

  localparam int W  = WORD_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [NW-1:0] num_r;
  logic [NW-1:0] q_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  dm_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          neg_r;
  logic          done_r;
  logic          ov_r;
  logic [W-1:0]  res_r;

  logic [W-1:0]  nm_in;
  logic [W-1:0]  dm_in;
  logic [W:0]    rem2;
  logic          fits;
  logic [NW-1:0] lim;
  logic          ovf;

  assign nm_in = num[W-1] ? W'(-num) : W'(num);
  assign dm_in = den[W-1] ? W'(-den) : W'(den);
  assign rem2  = {rem_r, num_r[NW-1]};
  assign fits  = rem2 >= {1'b0, dm_r};
  assign lim   = neg_r ? NW'(WMIN) : NW'(WMAX);
  assign ovf   = q_r > lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {nm_in, {FRAC_BITS{1'b0}}};
      dm_r  <= dm_in;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= num[W-1] ^ den[W-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        num_r <= num_r << 1;
        q_r   <= {q_r[NW-2:0], fits};
        rem_r <= fits ? W'(rem2 - {1'b0, dm_r}) : rem2[W-1:0];
      end else begin
        ov_r <= ovf;
        if (ovf) begin
          res_r <= neg_r ? WMIN : WMAX;
        end else begin
          res_r <= neg_r ? W'(-q_r[W-1:0]) : q_r[W-1:0];
        end
      end
    end
  end

  assign res       = res_r;
  assign stat.done = done_r;
  assign stat.ov   = ov_r;

endmodule

`default_nettype wire

[design/quartic_newton_root_refine.sv]
//------------------------------------------------------------------------------
// quartic_newton_root_refine
// Newton refinement of a quartic root on a shared serial multiplier and divider.
// Each update evaluates the quartic and its slope at the current guess, one
// product at a time on the multiplier, then divides value by slope and
// subtracts the quotient; the search stops on convergence, on a fault, or at
// the update limit (up to sixteen updates when the limit register holds 15).
// One guess is worked on at a time; a new word is taken after the result leaves.
// Synchronous reset clears the sequencer and loads the register defaults.
//------------------------------------------------------------------------------
`default_nettype none

module quartic_newton_root_refine
  import qnr_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  qnr_in_if.sink                      in_ch,
  qnr_out_if.source                   out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [WORD_WIDTH-1:0]  cfg_data
);

  localparam int W = WORD_WIDTH;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? WMIN : WMAX};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? WMIN : WMAX};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] a);
    return a[W-1] ? W'(-a) : a;
  endfunction

  logic [W-1:0]       c4_r, c3_r, c2_r, c1_r, c0_r;
  logic [W-2:0]       tol_r;
  logic [LIMIT_W-1:0] lim_r;

  state_t             state_r, state_nxt;
  step_t              step_r, step_nxt;
  logic [W-1:0]       x_r, x_nxt;
  logic [W-1:0]       x2_r, x2_nxt;
  logic [W-1:0]       x3_r, x3_nxt;
  logic [W-1:0]       x4_r, x4_nxt;
  logic [W-1:0]       s_r, s_nxt;
  logic [W-1:0]       f_r, f_nxt;
  logic [W-1:0]       g_r, g_nxt;
  logic               ov_r, ov_nxt;
  logic               first_r, first_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;

  logic [W:0]         k4a, k4, k3a, k3, k2;
  logic               kov;
  logic [W-1:0]       mul_a, mul_b, mul_res, div_res;
  unit_stat_t         mul_st, div_st;
  logic               mul_start, div_start;
  logic [W:0]         t1, t2;
  logic [CNT_W-1:0]   n_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r  <= '0;
      c3_r  <= '0;
      c2_r  <= '0;
      c1_r  <= '0;
      c0_r  <= '0;
      tol_r <= (W-1)'(1);
      lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_FOUR:  c4_r  <= cfg_data;
        CFG_COEF_THREE: c3_r  <= cfg_data;
        CFG_COEF_TWO:   c2_r  <= cfg_data;
        CFG_COEF_ONE:   c1_r  <= cfg_data;
        CFG_COEF_ZERO:  c0_r  <= cfg_data;
        CFG_TOLERANCE:  tol_r <= cfg_data[W-2:0];
        CFG_ITER_LIMIT: lim_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k4a = sadd(c4_r, c4_r);
    k4  = sadd(k4a[W-1:0], k4a[W-1:0]);
    k3a = sadd(c3_r, c3_r);
    k3  = sadd(k3a[W-1:0], c3_r);
    k2  = sadd(c2_r, c2_r);
    kov = k4a[W] | k4[W] | k3a[W] | k3[W] | k2[W];
  end

  always_comb begin
    unique case (step_r)
      STEP_X2:   begin mul_a = x_r;         mul_b = x_r;  end
      STEP_X3:   begin mul_a = x_r;         mul_b = x2_r; end
      STEP_X4:   begin mul_a = x_r;         mul_b = x3_r; end
      STEP_C4X4: begin mul_a = c4_r;        mul_b = x4_r; end
      STEP_C3X3: begin mul_a = c3_r;        mul_b = x3_r; end
      STEP_C2X2: begin mul_a = c2_r;        mul_b = x2_r; end
      STEP_C1X:  begin mul_a = c1_r;        mul_b = x_r;  end
      STEP_K4X3: begin mul_a = k4[W-1:0];   mul_b = x3_r; end
      STEP_K3X2: begin mul_a = k3[W-1:0];   mul_b = x2_r; end
      STEP_K2X:  begin mul_a = k2[W-1:0];   mul_b = x_r;  end
      default:   begin mul_a = x_r;         mul_b = x_r;  end
    endcase
  end

  assign mul_start = state_r == ST_MUL_ISSUE;
  assign div_start = state_r == ST_DIV_ISSUE;

  qnr_mul #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mul_res),
    .stat  (mul_st)
  );

  qnr_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (f_r),
    .den   (g_r),
    .res   (div_res),
    .stat  (div_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    x_r     <= x_nxt;
    x2_r    <= x2_nxt;
    x3_r    <= x3_nxt;
    x4_r    <= x4_nxt;
    s_r     <= s_nxt;
    f_r     <= f_nxt;
    g_r     <= g_nxt;
    ov_r    <= ov_nxt;
    first_r <= first_nxt;
    n_r     <= n_nxt;
    stat_r  <= stat_nxt;
  end

  assign n_inc = n_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    x3_nxt    = x3_r;
    x4_nxt    = x4_r;
    s_nxt     = s_r;
    f_nxt     = f_r;
    g_nxt     = g_r;
    ov_nxt    = ov_r;
    first_nxt = first_r;
    n_nxt     = n_r;
    stat_nxt  = stat_r;
    t1        = '0;
    t2        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          x_nxt     = in_ch.initial_guess;
          step_nxt  = STEP_X2;
          ov_nxt    = 1'b0;
          first_nxt = 1'b1;
          n_nxt     = '0;
          state_nxt = ST_MUL_ISSUE;
        end
      end
      ST_MUL_ISSUE: begin
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_st.done) begin
          state_nxt = ST_MUL_ISSUE;
          ov_nxt    = ov_r | mul_st.ov;
          unique case (step_r) inside
            STEP_X2: begin
              x2_nxt   = mul_res;
              step_nxt = STEP_X3;
            end
            STEP_X3: begin
              x3_nxt   = mul_res;
              step_nxt = STEP_X4;
            end
            STEP_X4: begin
              x4_nxt   = mul_res;
              step_nxt = STEP_C4X4;
            end
            STEP_C4X4: begin
              s_nxt    = mul_res;
              step_nxt = STEP_C3X3;
            end
            STEP_C3X3, STEP_C2X2: begin
              t1       = sadd(s_r, mul_res);
              s_nxt    = t1[W-1:0];
              ov_nxt   = ov_r | mul_st.ov | t1[W];
              step_nxt = (step_r == STEP_C3X3) ? STEP_C2X2 : STEP_C1X;
            end
            STEP_C1X: begin
              t1       = sadd(s_r, mul_res);
              t2       = sadd(t1[W-1:0], c0_r);
              f_nxt    = t2[W-1:0];
              ov_nxt   = ov_r | mul_st.ov | t1[W] | t2[W];
              step_nxt = STEP_K4X3;
              first_nxt = 1'b0;
              if (ov_nxt) begin
                stat_nxt  = STAT_FAULT;
                state_nxt = ST_OUT;
              end else if (first_r && mag(t2[W-1:0]) <= {1'b0, tol_r}) begin
                stat_nxt  = STAT_CONVERGED;
                state_nxt = ST_OUT;
              end
            end
            STEP_K4X3: begin
              s_nxt    = mul_res;
              step_nxt = STEP_K3X2;
            end
            STEP_K3X2: begin
              t1       = sadd(s_r, mul_res);
              s_nxt    = t1[W-1:0];
              ov_nxt   = ov_r | mul_st.ov | t1[W];
              step_nxt = STEP_K2X;
            end
            STEP_K2X: begin
              t1       = sadd(s_r, mul_res);
              t2       = sadd(t1[W-1:0], c1_r);
              g_nxt    = t2[W-1:0];
              ov_nxt   = ov_r | mul_st.ov | t1[W] | t2[W] | kov;
              if (ov_nxt || t2[W-1:0] == '0) begin
                stat_nxt  = STAT_FAULT;
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_DIV_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_ISSUE: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_st.done) begin
          t1    = ssub(x_r, div_res);
          x_nxt = t1[W-1:0];
          n_nxt = n_inc;
          if (div_st.ov || t1[W]) begin
            stat_nxt  = STAT_FAULT;
            state_nxt = ST_OUT;
          end else if (n_inc > {1'b0, lim_r}) begin
            stat_nxt  = STAT_LIMIT;
            state_nxt = ST_OUT;
          end else if (mag(f_r) <= {1'b0, tol_r}) begin
            stat_nxt  = STAT_CONVERGED;
            state_nxt = ST_OUT;
          end else begin
            step_nxt  = STEP_X2;
            state_nxt = ST_MUL_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready         = state_r == ST_IDLE;
  assign out_ch.valid        = state_r == ST_OUT;
  assign out_ch.root         = x_r;
  assign out_ch.status       = stat_r;
  assign out_ch.updates_done = n_r;

endmodule

`default_nettype wire

[test/qnr_tb_if.sv]
//------------------------------------------------------------------------------
// qnr_tb_if
// Expected result word type shared by the testbench.
// The channel interfaces themselves are the ones shipped with the design.
//------------------------------------------------------------------------------
package qnr_tb_pkg;
  typedef struct packed {
    logic signed [31:0] root;
    logic [1:0]         status;
    logic [4:0]         updates_done;
  } refined_root_t;
endpackage

[test/quartic_newton_root_refine_tb.sv]
//------------------------------------------------------------------------------
// quartic_newton_root_refine_tb
// Drives starting guesses into the Newton refiner under several polynomial
// settings and checks every root, status and update count against an
// independent fixed-point model of the iteration, with random burst and stall.
//------------------------------------------------------------------------------
module quartic_newton_root_refine_tb
  import qnr_pkg::*, qnr_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint LIMIT_CYCLES = 64'd8000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  qnr_in_if #(.WORD_WIDTH(32)) in_ch ();
  qnr_out_if #(.WORD_WIDTH(32)) out_ch ();

  quartic_newton_root_refine u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint coef [5];
  longint tol;
  int     iter_lim;

  logic [31:0]   guess_queue [$];
  refined_root_t root_queue [$];
  int     mismatches = 0;
  longint cycle_count = 0;
  bit     sending = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_phase = 0;

  function automatic longint sat(longint v, ref bit ov);
    if (v > WMAX) begin
      ov = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      ov = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b, ref bit ov);
    logic [127:0] p;
    logic [63:0] ma, mb;
    bit neg;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    p = (128'(ma) * 128'(mb)) >> 16;
    if (p > 128'(neg ? 64'h80000000 : 64'h7fffffff)) begin
      ov = 1'b1;
      return neg ? WMIN : WMAX;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint fx_div(longint n, longint d, ref bit ov);
    logic [127:0] q;
    logic [63:0] mn, md;
    bit neg;
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    neg = (n < 0) != (d < 0);
    q = (128'(mn) << 16) / 128'(md);
    if (q > 128'(neg ? 64'h80000000 : 64'h7fffffff)) begin
      ov = 1'b1;
      return neg ? WMIN : WMAX;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint quartic_at(longint x, ref bit ov);
    longint x2, x3, x4, s;
    x2 = fx_mul(x, x, ov);
    x3 = fx_mul(x, x2, ov);
    x4 = fx_mul(x, x3, ov);
    s = fx_mul(coef[0], x4, ov);
    s = sat(s + fx_mul(coef[1], x3, ov), ov);
    s = sat(s + fx_mul(coef[2], x2, ov), ov);
    s = sat(s + fx_mul(coef[3], x, ov), ov);
    return sat(s + coef[4], ov);
  endfunction

  function automatic longint slope_at(longint x, ref bit ov);
    longint k4, k3, k2, x2, x3, s;
    k4 = sat(coef[0] + coef[0], ov);
    k4 = sat(k4 + k4, ov);
    k3 = sat(sat(coef[1] + coef[1], ov) + coef[1], ov);
    k2 = sat(coef[2] + coef[2], ov);
    x2 = fx_mul(x, x, ov);
    x3 = fx_mul(x, x2, ov);
    s = fx_mul(k4, x3, ov);
    s = sat(s + fx_mul(k3, x2, ov), ov);
    s = sat(s + fx_mul(k2, x, ov), ov);
    return sat(s + coef[3], ov);
  endfunction

  function automatic refined_root_t refine_root(logic [31:0] guess);
    refined_root_t r;
    bit ov;
    longint x, f0, f, g;
    int n;
    logic [1:0] st;
    ov = 1'b0;
    x = longint'($signed(guess));
    n = 0;
    st = STAT_CONVERGED;
    f0 = quartic_at(x, ov);
    if (ov) begin
      st = STAT_FAULT;
    end else begin
      while ((f0 < 0 ? -f0 : f0) > tol) begin
        f = quartic_at(x, ov);
        if (ov) begin
          st = STAT_FAULT;
          break;
        end
        g = slope_at(x, ov);
        if (ov || g == 0) begin
          st = STAT_FAULT;
          break;
        end
        x = sat(x - fx_div(f, g, ov), ov);
        n++;
        f0 = f;
        if (ov) begin
          st = STAT_FAULT;
          break;
        end
        if (n > iter_lim) begin
          st = STAT_LIMIT;
          break;
        end
      end
    end
    r.root = x[31:0];
    r.status = st;
    r.updates_done = n[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.initial_guess <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        root_queue.push_back(refine_root(in_ch.initial_guess));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (sending && guess_queue.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.initial_guess <= guess_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(12, 1);
            gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(300, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stalls in a pattern of its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (root_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word root=%h status=%0d updates=%0d",
                     out_ch.root, out_ch.status, out_ch.updates_done);
        end else begin
          refined_root_t e;
          e = root_queue.pop_front();
          if (e.root !== out_ch.root || e.status !== out_ch.status ||
              e.updates_done !== out_ch.updates_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: expected root=%h status=%0d updates=%0d, ",
                        "got root=%h status=%0d updates=%0d"},
                       e.root, e.status, e.updates_done,
                       out_ch.root, out_ch.status, out_ch.updates_done);
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) out_ch.ready <= 1'b1;
      else if (stall_phase < 70) out_ch.ready <= ($urandom_range(3, 0) != 0);
      else out_ch.ready <= ($urandom_range(1, 0) != 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 5) coef[idx] = longint'($signed(val));
    else if (idx == CFG_TOLERANCE) tol = longint'(val[30:0]);
    else if (idx == CFG_ITER_LIMIT) iter_lim = int'(val[3:0]);
  endtask

  task automatic set_poly(logic [31:0] c4, logic [31:0] c3, logic [31:0] c2,
                          logic [31:0] c1, logic [31:0] c0, logic [31:0] tl,
                          logic [31:0] lm);
    write_reg(CFG_COEF_FOUR, c4);
    write_reg(CFG_COEF_THREE, c3);
    write_reg(CFG_COEF_TWO, c2);
    write_reg(CFG_COEF_ONE, c1);
    write_reg(CFG_COEF_ZERO, c0);
    write_reg(CFG_TOLERANCE, tl);
    write_reg(CFG_ITER_LIMIT, lm);
    write_reg(3'd7, $urandom);
  endtask

  task automatic drain();
    while (guess_queue.size() > 0 || in_ch.valid || root_queue.size() > 0)
      @(negedge clk);
    sending = 1'b0;
    repeat (2000) @(posedge clk);
  endtask

  function automatic logic [31:0] small_guess();
    int s;
    s = $urandom_range(3, 0);
    if (s == 0) return $urandom;
    return 32'($signed($urandom_range(20, 0) * 32'sd65536 - 32'sd655360 +
                       $signed($urandom_range(65535, 0))));
  endfunction

  initial begin
    int p;
    coef = '{0, 0, 0, 0, 0};
    tol = 1;
    iter_lim = 10;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: constant zero polynomial converges at once.
    guess_queue.push_back(32'h0);
    guess_queue.push_back(32'h7fffffff);
    guess_queue.push_back(32'h80000000);
    sending = 1'b1;
    drain();

    // x^2 - 2 with various guesses, zero derivative and overflow cases.
    set_poly(32'h0, 32'h0, 32'h10000, 32'h0, 32'hfffe0000, 32'd16, 32'd10);
    guess_queue.push_back(32'h10000);
    guess_queue.push_back(32'hffff0000);
    guess_queue.push_back(32'h0);
    guess_queue.push_back(32'h7fffffff);
    guess_queue.push_back(32'h80000000);
    guess_queue.push_back(32'h00000001);
    guess_queue.push_back(32'h00640000);
    sending = 1'b1;
    drain();

    // Limit zero, tolerance zero, extreme coefficients.
    set_poly(32'h0, 32'h0, 32'h10000, 32'h0, 32'hfffd0000, 32'd0, 32'd0);
    guess_queue.push_back(32'h30000);
    guess_queue.push_back(32'h1);
    sending = 1'b1;
    drain();
    set_poly(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'd15);
    guess_queue.push_back(32'h10000);
    guess_queue.push_back(32'h8000);
    guess_queue.push_back(32'h0);
    sending = 1'b1;
    drain();

    for (p = 0; p < 8; p++) begin
      set_poly(p == 7 ? $urandom : $urandom_range(4, 0) * 32'h4000,
               $signed($urandom_range(8, 0) * 32'h8000) - 32'sh20000,
               $signed($urandom_range(16, 0) * 32'h10000) - 32'sh80000,
               p == 6 ? $urandom : $signed($urandom_range(64, 0) * 32'h8000) - 32'sh100000,
               $signed($urandom_range(32, 0) * 32'h10000) - 32'sh100000,
               p == 5 ? $urandom : $urandom_range(4096, 0),
               p == 4 ? 32'd15 : $urandom_range(15, 1));
      repeat (119) guess_queue.push_back(small_guess());
      if (p == 3) begin
        sending = 1'b1;
        while (guess_queue.size() > 60) @(posedge clk);
        sending = 1'b0;
        @(negedge clk);
        while (in_ch.valid || root_queue.size() > 0) @(negedge clk);
      end
      sending = 1'b1;
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[filelist.f]
design/qnr_pkg.sv
design/qnr_if.sv
design/qnr_mul.sv
design/qnr_div.sv
design/quartic_newton_root_refine.sv
test/qnr_tb_if.sv
test/quartic_newton_root_refine_tb.sv
